### rtl/tds_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tds_pkg;

    // Largest system that the coefficient stores can hold.
    localparam int MAX_ROWS = 64;
    localparam int ADDR_W   = $clog2(MAX_ROWS);
    localparam int COUNT_W  = $clog2(MAX_ROWS + 1);

    // Quotient bits resolved by the divider; the bits above are covered by a
    // single compare before the first step.
    localparam int DIV_STEPS = 33;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_PIVOT = 2'd1;
    localparam logic [1:0] ST_ROWS  = 2'd2;
    localparam logic [1:0] ST_OVF   = 2'd3;

    // One row of the system as it travels from the front end to the solver core.
    typedef struct packed {
        logic signed [31:0] sub_coef;
        logic signed [31:0] diag_coef;
        logic signed [31:0] super_coef;
        logic signed [31:0] rhs_value;
        logic               last_row;
        logic               first_row;
    } row_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_G,
        S_ALPHA,
        S_MUL_P,
        S_NUM,
        S_DIV,
        S_FINISH,
        S_ERR,
        S_BS_RD,
        S_BS_LOAD,
        S_BS_MUL,
        S_BS_SUB,
        S_EMIT
    } core_state_t;

endpackage

`default_nettype wire

### rtl/tds_front.sv
`timescale 1ns / 1ps
`default_nettype none

module tds_front (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_ready,
    input  wire  signed [31:0]  sub_coef,
    input  wire  signed [31:0]  diag_coef,
    input  wire  signed [31:0]  super_coef,
    input  wire  signed [31:0]  rhs_value,
    input  wire                 last_row,
    output logic                q_valid,
    input  wire                 q_ready,
    output tds_pkg::row_t       q_row
);
    import tds_pkg::*;

    row_t       fifo_mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       first_reg, first_next;
    logic       push, pop;

    assign in_ready = (count_reg != 2'd2);
    assign q_valid  = (count_reg != 2'd0);
    assign q_row    = fifo_mem[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    // A row is the first of its system when the row before it carried the last mark.
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
        first_next  = push ? last_row : first_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
            first_reg  <= 1'b1;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
            first_reg  <= first_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem[wr_ptr_reg] <= '{sub_coef: sub_coef, diag_coef: diag_coef,
                                      super_coef: super_coef, rhs_value: rhs_value,
                                      last_row: last_row, first_row: first_reg};
        end
    end

endmodule

`default_nettype wire

### rtl/tds_div.sv
`timescale 1ns / 1ps
`default_nettype none

module tds_div (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 start,
    input  wire  signed [64:0]  num_a,
    input  wire  signed [64:0]  num_b,
    input  wire  signed [31:0]  den,
    output logic                done,
    output logic [31:0]         quo_a,
    output logic [31:0]         quo_b,
    output logic                ovf_a,
    output logic                ovf_b
);
    import tds_pkg::*;

    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 done_reg, done_next;
    logic [31:0]          dmag_reg, dmag_next;
    logic [31:0]          rem_a_reg, rem_a_next, rem_b_reg, rem_b_next;
    logic [32:0]          low_a_reg, low_a_next, low_b_reg, low_b_next;
    logic [32:0]          q_a_reg, q_a_next, q_b_reg, q_b_next;
    logic                 neg_a_reg, neg_a_next, neg_b_reg, neg_b_next;
    logic                 big_a_reg, big_a_next, big_b_reg, big_b_next;
    logic [64:0]          mag_a, mag_b;
    logic [31:0]          dmag_in;
    logic [32:0]          trial_a, trial_b;
    logic [32:0]          res_a, res_b;

    assign mag_a   = num_a[64] ? 65'(-num_a) : num_a;
    assign mag_b   = num_b[64] ? 65'(-num_b) : num_b;
    assign dmag_in = den[31] ? 32'(-den) : den;
    assign trial_a = {rem_a_reg, low_a_reg[32]};
    assign trial_b = {rem_b_reg, low_b_reg[32]};

    always_comb
    begin
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        dmag_next  = dmag_reg;
        rem_a_next = rem_a_reg;
        rem_b_next = rem_b_reg;
        low_a_next = low_a_reg;
        low_b_next = low_b_reg;
        q_a_next   = q_a_reg;
        q_b_next   = q_b_reg;
        neg_a_next = neg_a_reg;
        neg_b_next = neg_b_reg;
        big_a_next = big_a_reg;
        big_b_next = big_b_reg;
        if (start)
        begin
            // Quotients of 2^33 or more are flagged at once; the rest resolve bit by bit.
            cnt_next   = DIV_CNT_W'(DIV_STEPS);
            dmag_next  = dmag_in;
            rem_a_next = mag_a[64:33];
            rem_b_next = mag_b[64:33];
            low_a_next = mag_a[32:0];
            low_b_next = mag_b[32:0];
            q_a_next   = '0;
            q_b_next   = '0;
            neg_a_next = num_a[64] ^ den[31];
            neg_b_next = num_b[64] ^ den[31];
            big_a_next = (mag_a[64:33] >= dmag_in);
            big_b_next = (mag_b[64:33] >= dmag_in);
        end
        else if (cnt_reg != '0)
        begin
            low_a_next = {low_a_reg[31:0], 1'b0};
            low_b_next = {low_b_reg[31:0], 1'b0};
            if (trial_a >= {1'b0, dmag_reg})
            begin
                rem_a_next = 32'(trial_a - {1'b0, dmag_reg});
                q_a_next   = {q_a_reg[31:0], 1'b1};
            end
            else
            begin
                rem_a_next = trial_a[31:0];
                q_a_next   = {q_a_reg[31:0], 1'b0};
            end
            if (trial_b >= {1'b0, dmag_reg})
            begin
                rem_b_next = 32'(trial_b - {1'b0, dmag_reg});
                q_b_next   = {q_b_reg[31:0], 1'b1};
            end
            else
            begin
                rem_b_next = trial_b[31:0];
                q_b_next   = {q_b_reg[31:0], 1'b0};
            end
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == DIV_CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dmag_reg  <= dmag_next;
        rem_a_reg <= rem_a_next;
        rem_b_reg <= rem_b_next;
        low_a_reg <= low_a_next;
        low_b_reg <= low_b_next;
        q_a_reg   <= q_a_next;
        q_b_reg   <= q_b_next;
        neg_a_reg <= neg_a_next;
        neg_b_reg <= neg_b_next;
        big_a_reg <= big_a_next;
        big_b_reg <= big_b_next;
    end

    assign res_a = neg_a_reg ? 33'(-q_a_reg) : q_a_reg;
    assign res_b = neg_b_reg ? 33'(-q_b_reg) : q_b_reg;
    assign quo_a = res_a[31:0];
    assign quo_b = res_b[31:0];
    assign done  = done_reg;
    assign ovf_a = big_a_reg || (neg_a_reg ? (q_a_reg > 33'h080000000)
                                           : (q_a_reg > 33'h07FFFFFFF));
    assign ovf_b = big_b_reg || (neg_b_reg ? (q_b_reg > 33'h080000000)
                                           : (q_b_reg > 33'h07FFFFFFF));

endmodule

`default_nettype wire

### rtl/tds_core.sv
`timescale 1ns / 1ps
`default_nettype none

module tds_core (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 q_valid,
    output logic                q_ready,
    input  tds_pkg::row_t       q_row,
    output logic                out_valid,
    input  wire                 out_ready,
    output logic [5:0]          row_index,
    output logic signed [31:0]  solution_value,
    output logic                last_result,
    output logic [1:0]          status
);
    import tds_pkg::*;

    core_state_t         state_reg, state_next;
    row_t                row_reg, row_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic signed [31:0]  pg_reg, pg_next, pp_reg, pp_next;
    logic [1:0]          err_reg, err_next;
    logic signed [63:0]  prod_reg, prod_next;
    logic signed [31:0]  alpha_reg, alpha_next;
    logic [ADDR_W-1:0]   idx_reg, idx_next;
    logic                bs_first_reg, bs_first_next;
    logic signed [31:0]  x_reg, x_next;

    logic                out_valid_reg, out_valid_next;
    logic [5:0]          out_idx_reg, out_idx_next;
    logic signed [31:0]  out_val_reg, out_val_next;
    logic                out_last_reg, out_last_next;
    logic [1:0]          out_st_reg, out_st_next;

    logic signed [31:0]  gamma_mem [MAX_ROWS];
    logic signed [31:0]  part_mem  [MAX_ROWS];
    logic signed [31:0]  gam_rd_reg, g_rd_reg;
    logic                wr_en, rd_en;
    logic signed [31:0]  wr_gam, wr_g;

    logic signed [31:0]  mul_a, mul_b;
    logic signed [63:0]  mul_p;
    logic signed [48:0]  prod_q, alpha_w, num_w, diff_w;
    logic signed [31:0]  sub_sel;
    logic                div_start, div_done, div_ovf_g, div_ovf_gam;
    logic [31:0]         div_g, div_gam;
    logic                out_free;

    assign sub_sel = row_reg.first_row ? 32'sd0 : row_reg.sub_coef;
    assign mul_p   = mul_a * mul_b;
    assign prod_q  = {prod_reg[63], prod_reg[63:16]};
    assign alpha_w = {{17{row_reg.diag_coef[31]}}, row_reg.diag_coef} - prod_q;
    assign num_w   = {{17{row_reg.rhs_value[31]}}, row_reg.rhs_value} - prod_q;
    assign diff_w  = {{17{g_rd_reg[31]}}, g_rd_reg} - prod_q;
    assign out_free = !out_valid_reg || out_ready;

    tds_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num_a ({num_w, 16'd0}),
        .num_b ({{17{row_reg.super_coef[31]}}, row_reg.super_coef, 16'd0}),
        .den   (alpha_reg),
        .done  (div_done),
        .quo_a (div_g),
        .quo_b (div_gam),
        .ovf_a (div_ovf_g),
        .ovf_b (div_ovf_gam)
    );

    always_comb
    begin
        state_next     = state_reg;
        row_next       = row_reg;
        count_next     = count_reg;
        pg_next        = pg_reg;
        pp_next        = pp_reg;
        err_next       = err_reg;
        prod_next      = prod_reg;
        alpha_next     = alpha_reg;
        idx_next       = idx_reg;
        bs_first_next  = bs_first_reg;
        x_next         = x_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_idx_next   = out_idx_reg;
        out_val_next   = out_val_reg;
        out_last_next  = out_last_reg;
        out_st_next    = out_st_reg;
        q_ready        = 1'b0;
        wr_en          = 1'b0;
        rd_en          = 1'b0;
        wr_gam         = 32'sd0;
        wr_g           = div_g;
        div_start      = 1'b0;
        mul_a          = sub_sel;
        mul_b          = pg_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                q_ready = 1'b1;
                if (q_valid)
                begin
                    row_next = q_row;
                    if (err_reg != ST_OK)
                        state_next = S_FINISH;
                    else if (count_reg == COUNT_W'(MAX_ROWS))
                    begin
                        err_next   = ST_ROWS;
                        state_next = S_FINISH;
                    end
                    else
                        state_next = S_MUL_G;
                end
            end
            S_MUL_G:
            begin
                prod_next  = mul_p;
                state_next = S_ALPHA;
            end
            S_ALPHA:
            begin
                if (!((&alpha_w[48:31]) || !(|alpha_w[48:31])))
                begin
                    err_next   = ST_OVF;
                    state_next = S_FINISH;
                end
                else if (alpha_w == 49'sd0)
                begin
                    err_next   = ST_PIVOT;
                    state_next = S_FINISH;
                end
                else
                begin
                    alpha_next = alpha_w[31:0];
                    state_next = S_MUL_P;
                end
            end
            S_MUL_P:
            begin
                mul_b      = pp_reg;
                prod_next  = mul_p;
                state_next = S_NUM;
            end
            S_NUM:
            begin
                div_start  = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    if (div_ovf_g || (!row_reg.last_row && div_ovf_gam))
                        err_next = ST_OVF;
                    else
                    begin
                        wr_en      = 1'b1;
                        wr_gam     = row_reg.last_row ? 32'sd0 : div_gam;
                        pg_next    = wr_gam;
                        pp_next    = div_g;
                        count_next = count_reg + 1'b1;
                    end
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!row_reg.last_row)
                    state_next = S_IDLE;
                else if (err_reg != ST_OK || count_reg == '0)
                    state_next = S_ERR;
                else
                begin
                    idx_next      = ADDR_W'(count_reg - 1'b1);
                    bs_first_next = 1'b1;
                    state_next    = S_BS_RD;
                end
            end
            S_ERR:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_idx_next   = 6'd0;
                    out_val_next   = 32'sd0;
                    out_last_next  = 1'b1;
                    out_st_next    = err_reg;
                    count_next     = '0;
                    pg_next        = 32'sd0;
                    pp_next        = 32'sd0;
                    err_next       = ST_OK;
                    state_next     = S_IDLE;
                end
            end
            S_BS_RD:
            begin
                rd_en      = 1'b1;
                state_next = bs_first_reg ? S_BS_LOAD : S_BS_MUL;
            end
            S_BS_LOAD:
            begin
                x_next     = g_rd_reg;
                state_next = S_EMIT;
            end
            S_BS_MUL:
            begin
                mul_a      = gam_rd_reg;
                mul_b      = x_reg;
                prod_next  = mul_p;
                state_next = S_BS_SUB;
            end
            S_BS_SUB:
            begin
                if (!diff_w[48] && (|diff_w[47:31]))
                    x_next = 32'sh7FFFFFFF;
                else if (diff_w[48] && !(&diff_w[47:31]))
                    x_next = 32'sh80000000;
                else
                    x_next = diff_w[31:0];
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_idx_next   = 6'(idx_reg);
                    out_val_next   = x_reg;
                    out_last_next  = (idx_reg == '0);
                    out_st_next    = ST_OK;
                    if (idx_reg == '0)
                    begin
                        count_next = '0;
                        pg_next    = 32'sd0;
                        pp_next    = 32'sd0;
                        err_next   = ST_OK;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next      = idx_reg - 1'b1;
                        bs_first_next = 1'b0;
                        state_next    = S_BS_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            pg_reg        <= 32'sd0;
            pp_reg        <= 32'sd0;
            err_reg       <= ST_OK;
            out_valid_reg <= 1'b0;
            bs_first_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pg_reg        <= pg_next;
            pp_reg        <= pp_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
            bs_first_reg  <= bs_first_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg      <= row_next;
        prod_reg     <= prod_next;
        alpha_reg    <= alpha_next;
        idx_reg      <= idx_next;
        x_reg        <= x_next;
        out_idx_reg  <= out_idx_next;
        out_val_reg  <= out_val_next;
        out_last_reg <= out_last_next;
        out_st_reg   <= out_st_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            gamma_mem[count_reg[ADDR_W-1:0]] <= wr_gam;
            part_mem[count_reg[ADDR_W-1:0]]  <= wr_g;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            gam_rd_reg <= gamma_mem[idx_reg];
            g_rd_reg   <= part_mem[idx_reg];
        end
    end

    assign out_valid      = out_valid_reg;
    assign row_index      = out_idx_reg;
    assign solution_value = out_val_reg;
    assign last_result    = out_last_reg;
    assign status         = out_st_reg;

endmodule

`default_nettype wire

### rtl/tridiagonal_system_solver.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Handshake             Beat contents
// -------  --------------------  ------------------------------------------------
// rows in  in_valid / in_ready   sub_coef, diag_coef, super_coef, rhs_value, last_row
// x out    out_valid / out_ready row_index, solution_value, last_result, status
//
// In the solver core each row beat costs two shared 32x32 multiplies and a
// 33-step restoring divider that forms g and gamma together. On the last row
// the back substitution gives result beats from the highest index down to zero,
// or a single error beat for a faulted run, each waiting while the output is full.
// A two-entry queue lets the front end take rows while the core is busy, and
// the output register lets the core move on while a result beat waits.
// Reset is asynchronous and active low; the coefficient stores need no clearing.
module tridiagonal_system_solver (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_ready,
    input  wire  signed [31:0]  sub_coef,
    input  wire  signed [31:0]  diag_coef,
    input  wire  signed [31:0]  super_coef,
    input  wire  signed [31:0]  rhs_value,
    input  wire                 last_row,
    output logic                out_valid,
    input  wire                 out_ready,
    output logic [5:0]          row_index,
    output logic signed [31:0]  solution_value,
    output logic                last_result,
    output logic [1:0]          status
);
    import tds_pkg::*;

    logic q_valid;
    logic q_ready;
    row_t q_row;

    // The front end tags each row with whether it opens a system and queues it.
    tds_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .sub_coef   (sub_coef),
        .diag_coef  (diag_coef),
        .super_coef (super_coef),
        .rhs_value  (rhs_value),
        .last_row   (last_row),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .q_row      (q_row)
    );

    // The core runs the forward sweep per row and the back substitution per system.
    tds_core u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_valid),
        .q_ready        (q_ready),
        .q_row          (q_row),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .row_index      (row_index),
        .solution_value (solution_value),
        .last_result    (last_result),
        .status         (status)
    );

endmodule

`default_nettype wire
